>>> hw/rtl/crng_pkg.sv
package crng_pkg;

   // table geometry
   localparam int TABLE_SIZE = 32;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W      = $clog2(TABLE_SIZE + 8);
   localparam int WORD_W     = 31;

   // generator constants
   localparam logic [WORD_W-1:0] MOD1 = 31'd2147483563;
   localparam logic [WORD_W-1:0] MOD2 = 31'd2147483399;
   localparam logic [WORD_W-1:0] TOP1 = MOD1 - 31'd1;
   localparam logic [15:0]       MUL1 = 16'd40014;
   localparam logic [15:0]       MUL2 = 16'd40692;

   // 2^31 folds back as (2^31 - modulus)
   localparam logic [7:0] FOLD1 = 8'(32'h8000_0000 - 32'(MOD1));
   localparam logic [7:0] FOLD2 = 8'(32'h8000_0000 - 32'(MOD2));

   // bucket width for the table index and its rounded-up reciprocal
   localparam int BUCKET       = 1 + int'(TOP1) / TABLE_SIZE;
   localparam int BUCKET_LOG   = $clog2(BUCKET);
   localparam int RECIP_SHIFT  = WORD_W + BUCKET_LOG;
   localparam int QUOT_W       = 2 * WORD_W + 1 - RECIP_SHIFT;
   localparam logic [63:0] RECIP_NUM  = 64'd1 << RECIP_SHIFT;
   localparam logic [63:0] RECIP_FULL =
      (RECIP_NUM + 64'(BUCKET) - 64'd1) / 64'(BUCKET);
   localparam logic [31:0] RECIP = RECIP_FULL[31:0];

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED_MUL,
      ST_SEED_ADD,
      ST_SEED_FOLD,
      ST_DRAW_LOAD,
      ST_DRAW_ADD,
      ST_DRAW_FOLD,
      ST_DRAW_MIX
   } crng_state_type;

endpackage

>>> hw/rtl/crng_ram.sv
module crng_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 31
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/crng_mod_step.sv
module crng_mod_step (
   input  logic                       clock,
   input  logic [crng_pkg::WORD_W-1:0] operand_i,
   input  logic [15:0]                mult_i,
   input  logic [7:0]                 fold_i,
   input  logic [crng_pkg::WORD_W-1:0] modulus_i,
   output logic [crng_pkg::WORD_W-1:0] result_o
);

   import crng_pkg::*;

   logic [WORD_W+15:0] prod_ff;
   logic [WORD_W+15:0] prod_in;
   logic [WORD_W:0]    sum_ff;
   logic [WORD_W:0]    sum_in;
   logic [23:0]        fold_prod;
   logic [WORD_W:0]    sum_sub;

   // stage 1: full product
   assign prod_in = (WORD_W + 16)'(operand_i) * (WORD_W + 16)'(mult_i);

   // stage 2: fold the bits above 2^31 back in
   assign fold_prod = 24'(prod_ff[WORD_W+15:WORD_W]) * 24'(fold_i);
   assign sum_in    = {1'b0, prod_ff[WORD_W-1:0]} + (WORD_W + 1)'(fold_prod);

   // stage 3: the folded sum stays below twice the modulus
   assign sum_sub  = sum_ff - {1'b0, modulus_i};
   assign result_o = (sum_ff >= {1'b0, modulus_i}) ? sum_sub[WORD_W-1:0]
                                                   : sum_ff[WORD_W-1:0];

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

endmodule

>>> hw/rtl/crng_index.sv
module crng_index (
   input  logic                       clock,
   input  logic [crng_pkg::WORD_W-1:0] last_i,
   output logic [crng_pkg::IDX_W-1:0]  index_o
);

   import crng_pkg::*;

   logic [2*WORD_W:0] prod_ff;
   logic [2*WORD_W:0] prod_in;
   logic [QUOT_W-1:0] quot;

   // divide by the bucket width through its rounded-up reciprocal
   assign prod_in = (2 * WORD_W + 1)'(last_i) * (2 * WORD_W + 1)'(RECIP);
   assign quot    = prod_ff[2*WORD_W:RECIP_SHIFT];

   // saturate at the top entry
   assign index_o = (32'(quot) >= 32'(TABLE_SIZE)) ? IDX_W'(TABLE_SIZE - 1)
                                                   : IDX_W'(32'(quot));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

>>> hw/rtl/combined_lcg_shuffle_rng_unit.sv
// Combined congruential random generator with a shuffle table. Each request
// transfer returns one deviate numerator N in 1..2147483562 (deviate is N over
// 2147483563). A plain draw steps through the draw add, fold and mix states:
// the three-stage modular step (multiply, fold, reduce) and then the mix that
// follows the registered table read. The mix state waits while an earlier
// result is still stalled. The result is registered, and the next request can
// be taken the cycle after it is loaded; no new request is taken while a draw
// or a seeding is in progress. A request with op 1, or any draw before the
// first seeding, first runs 40 generator steps. The result register holds a
// finished deviate while the next request is already being worked on.
module combined_lcg_shuffle_rng_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_op,
   input  logic [crng_pkg::WORD_W-1:0] req_seed_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [crng_pkg::WORD_W-1:0] rsp_deviate_numerator
);

   import crng_pkg::*;

   crng_state_type state_ff, state_in;

   logic [WORD_W-1:0] x_ff, x_in;
   logic [WORD_W-1:0] y_ff, y_in;
   logic [WORD_W-1:0] last_ff, last_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_data_ff, rsp_data_in;

   logic [WORD_W-1:0] x_next;
   logic [WORD_W-1:0] y_next;
   logic [IDX_W-1:0]  idx_calc;
   logic [WORD_W-1:0] tab_rd_data;

   logic              accept;
   logic              need_seed;
   logic              proceed;
   logic              seed_load;
   logic              x_step;
   logic              y_step;
   logic              tab_wr;
   logic              tab_rd;
   logic              last_from_x;
   logic              result_load;
   logic              cnt_dec;
   logic [IDX_W-1:0]  tab_wr_addr;
   logic [WORD_W-1:0] tab_wr_data;

   logic [WORD_W-1:0] seed_red;
   logic [WORD_W-1:0] seed_init;
   logic [WORD_W:0]   mix_diff;
   logic [WORD_W:0]   mix_wrap;
   logic [WORD_W-1:0] mix;

   // generator steps and table index
   crng_mod_step u_step_first (
      .clock     (clock),
      .operand_i (x_ff),
      .mult_i    (MUL1),
      .fold_i    (FOLD1),
      .modulus_i (MOD1),
      .result_o  (x_next)
   );

   crng_mod_step u_step_second (
      .clock     (clock),
      .operand_i (y_ff),
      .mult_i    (MUL2),
      .fold_i    (FOLD2),
      .modulus_i (MOD2),
      .result_o  (y_next)
   );

   crng_index u_index (
      .clock   (clock),
      .last_i  (last_ff),
      .index_o (idx_calc)
   );

   // shuffle table
   crng_ram #(
      .DEPTH (TABLE_SIZE),
      .WIDTH (WORD_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tab_wr),
      .wr_addr (tab_wr_addr),
      .wr_data (tab_wr_data),
      .rd_en   (tab_rd),
      .rd_addr (idx_calc),
      .rd_data (tab_rd_data)
   );

   // request handshake
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign need_seed = req_op || (x_ff == '0);
   assign proceed   = !rsp_valid_ff || !rsp_stall;

   // seed reduction, zero becomes one
   assign seed_red  = (req_seed_value >= MOD1) ? (req_seed_value - MOD1)
                                               : req_seed_value;
   assign seed_init = (seed_red == '0) ? WORD_W'(1) : seed_red;

   // table entry minus second generator, wrapped into 1..TOP1
   assign mix_diff = {1'b0, tab_rd_data} - {1'b0, y_ff};
   assign mix_wrap = mix_diff + {1'b0, TOP1};
   assign mix      = (mix_diff[WORD_W] || (mix_diff == '0)) ? mix_wrap[WORD_W-1:0]
                                                            : mix_diff[WORD_W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = need_seed ? ST_SEED_MUL : ST_DRAW_ADD;
            end
         end
         ST_SEED_MUL:  state_in = ST_SEED_ADD;
         ST_SEED_ADD:  state_in = ST_SEED_FOLD;
         ST_SEED_FOLD: state_in = (cnt_ff == '0) ? ST_DRAW_LOAD : ST_SEED_MUL;
         ST_DRAW_LOAD: state_in = ST_DRAW_ADD;
         ST_DRAW_ADD:  state_in = ST_DRAW_FOLD;
         ST_DRAW_FOLD: state_in = ST_DRAW_MIX;
         ST_DRAW_MIX: begin
            if (proceed) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall   = 1'b1;
      seed_load   = 1'b0;
      x_step      = 1'b0;
      y_step      = 1'b0;
      tab_wr      = 1'b0;
      tab_rd      = 1'b0;
      last_from_x = 1'b0;
      result_load = 1'b0;
      cnt_dec     = 1'b0;
      tab_wr_addr = idx_ff;
      tab_wr_data = x_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            seed_load = accept && need_seed;
         end
         ST_SEED_FOLD: begin
            x_step      = 1'b1;
            cnt_dec     = 1'b1;
            tab_wr      = 32'(cnt_ff) < 32'(TABLE_SIZE);
            tab_wr_addr = cnt_ff[IDX_W-1:0];
            tab_wr_data = x_next;
            last_from_x = (cnt_ff == '0);
         end
         ST_DRAW_ADD: begin
            tab_rd = 1'b1;
         end
         ST_DRAW_FOLD: begin
            x_step = 1'b1;
            y_step = 1'b1;
         end
         ST_DRAW_MIX: begin
            tab_wr      = proceed;
            result_load = proceed;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (seed_load) begin
         x_in   = seed_init;
         y_in   = seed_init;
         cnt_in = CNT_W'(TABLE_SIZE + 7);
      end
      if (x_step) begin
         x_in = x_next;
      end
      if (y_step) begin
         y_in = y_next;
      end
      if (cnt_dec) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
      if (last_from_x) begin
         last_in = x_next;
      end
      if (tab_rd) begin
         idx_in = idx_calc;
      end
      if (result_load) begin
         last_in      = mix;
         rsp_data_in  = mix;
         rsp_valid_in = 1'b1;
      end
   end

   // control and generator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         x_ff         <= '0;
         y_ff         <= '0;
         last_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_deviate_numerator = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // a request is only taken while the input is open
   a_accept_open: assert property (@(posedge clock) disable iff (reset)
      accept |-> !req_stall)
      else $error("request taken while stalled");

   // table is never read and written in the same cycle
   a_table_port: assert property (@(posedge clock) disable iff (reset)
      !(tab_wr && tab_rd))
      else $error("table read and write overlap");

   // a delivered deviate is always within 1..TOP1
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_data_ff != '0) && (rsp_data_ff <= TOP1)))
      else $error("deviate out of range");

   // the first generator is seeded whenever an item is in flight
   a_seeded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (x_ff != '0))
      else $error("first generator zero while busy");

   // the last seeding step hands over to the draw
   a_seed_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SEED_FOLD) && (cnt_ff == '0)) |=> (state_ff == ST_DRAW_LOAD))
      else $error("seeding did not finish into a draw");

   // a stalled result is not overwritten
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result lost");
`endif

endmodule

>>> bench/combined_lcg_shuffle_rng_unit_test.sv
module combined_lcg_shuffle_rng_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DW = crng_pkg::WORD_W;
   localparam int SLOTS = crng_pkg::TABLE_SIZE;

   // generator constants kept apart from the design's own
   localparam logic [63:0] FIRST_MOD    = 64'd2147483563;
   localparam logic [63:0] SECOND_MOD   = 64'd2147483399;
   localparam logic [63:0] FIRST_MUL    = 64'd40014;
   localparam logic [63:0] SECOND_MUL   = 64'd40692;
   localparam logic [63:0] WRAP_TOP     = FIRST_MOD - 64'd1;
   localparam logic [63:0] BUCKET_WIDTH = 64'd1 + WRAP_TOP / 64'(SLOTS);

   localparam int RANDOM_ITEMS = 430;
   localparam int IDLE_LIMIT   = 3000;
   localparam int SETTLE_CYCLES = 30;

   typedef enum logic {
      OP_DRAW   = 1'b0,
      OP_RESEED = 1'b1
   } rng_op_type;

   typedef struct packed {
      rng_op_type    op;
      logic [DW-1:0] seed;
   } stim_row_type;

   // directed rows, all checked against the shadow generator
   localparam int DIRECTED_COUNT = 22;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{OP_DRAW,   31'd5},            // draw before any seeding seeds first
      '{OP_DRAW,   31'h7FFF_FFFF},    // seed field ignored once seeded
      '{OP_DRAW,   31'd0},
      '{OP_DRAW,   31'd12345},
      '{OP_RESEED, 31'd0},            // zero seed acts as one
      '{OP_DRAW,   31'd0},
      '{OP_RESEED, 31'd1},            // must repeat the zero-seed draw
      '{OP_RESEED, 31'd2147483562},   // largest legal seed
      '{OP_DRAW,   31'd2147483562},
      '{OP_RESEED, 31'd2147483563},   // wraps to zero, then one
      '{OP_RESEED, 31'd2147483564},   // wraps to one
      '{OP_RESEED, 31'h7FFF_FFFF},    // top of the field
      '{OP_RESEED, 31'd2147483399},   // second generator stuck at zero
      '{OP_DRAW,   31'd0},
      '{OP_DRAW,   31'h2AAA_AAAA},
      '{OP_DRAW,   31'h5555_5555},
      '{OP_DRAW,   31'd0},
      '{OP_RESEED, 31'd123456789},
      '{OP_DRAW,   31'h2AAA_AAAA},
      '{OP_DRAW,   31'h5555_5555},
      '{OP_RESEED, 31'h4000_0000},
      '{OP_DRAW,   31'd0}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_op = 1'b0;
   logic [DW-1:0] req_seed_value = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [DW-1:0] rsp_deviate_numerator;

   // shadow generator state
   logic [DW-1:0] gen_a;
   logic [DW-1:0] gen_b;
   logic [DW-1:0] prev_deviate;
   logic [DW-1:0] shuffle_bank [SLOTS];

   logic [DW-1:0] pending_deviates [$];
   int            mismatch_count = 0;
   int            send_idle_pct = 30;
   int            recv_idle_pct = 30;
   int            stall_left = 0;
   int            idle_cycles = 0;

   combined_lcg_shuffle_rng_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_op                (req_op),
      .req_seed_value        (req_seed_value),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_deviate_numerator (rsp_deviate_numerator)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [DW-1:0] mcg_step(logic [DW-1:0] x, logic [63:0] mul,
                                               logic [63:0] modulus);
      return DW'((64'(x) * mul) % modulus);
   endfunction

   // mostly short gaps, a few long ones, none when pct is zero
   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [DW-1:0] pick_seed();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return DW'(WRAP_TOP);
         2: return DW'(FIRST_MOD);
         3: return '1;
         4: return DW'(SECOND_MOD);
         5: return DW'($urandom_range(1, 1000));
         default: return DW'($urandom);
      endcase
   endfunction

   // load both generators, warm up and fill the shuffle bank top down
   function automatic void reseed_shadow(logic [DW-1:0] seed);
      logic [31:0] s;
      s = {1'b0, seed};
      if (s >= 32'(FIRST_MOD))
         s -= 32'(FIRST_MOD);
      if (s == 32'd0)
         s = 32'd1;
      gen_a = DW'(s);
      gen_b = DW'(s);
      for (int i = SLOTS + 7; i >= 0; i--) begin
         gen_a = mcg_step(gen_a, FIRST_MUL, FIRST_MOD);
         if (i < SLOTS)
            shuffle_bank[i] = gen_a;
      end
      prev_deviate = shuffle_bank[0];
   endfunction

   // next deviate numerator for one accepted request
   function automatic void predict_deviate(rng_op_type op, logic [DW-1:0] seed);
      int     slot;
      longint mix;
      if (op == OP_RESEED || gen_a == '0)
         reseed_shadow(seed);
      gen_a = mcg_step(gen_a, FIRST_MUL, FIRST_MOD);
      gen_b = mcg_step(gen_b, SECOND_MUL, SECOND_MOD);
      slot = int'(64'(prev_deviate) / BUCKET_WIDTH);
      if (slot >= SLOTS)
         slot = SLOTS - 1;
      mix = longint'(shuffle_bank[slot]) - longint'(gen_b);
      shuffle_bank[slot] = gen_a;
      if (mix < 1)
         mix += longint'(WRAP_TOP);
      prev_deviate = DW'(mix);
      pending_deviates.push_back(prev_deviate);
   endfunction

   task automatic report_mismatch(string what, logic [DW-1:0] want, logic [DW-1:0] got);
      $display("mismatch at %0t: %s, expected %0d got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // one request transfer, with an optional gap in front
   task automatic send_request(rng_op_type op, logic [DW-1:0] seed);
      int gap;
      gap = pick_gap(send_idle_pct);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_seed_value <= seed;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_deviate(op, seed);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_deviates.size() != 0)
         @(posedge clock);
   endtask

   // result side stall pattern
   always @(posedge clock) begin
      if (stall_left > 0)
         stall_left--;
      else
         stall_left = pick_gap(recv_idle_pct);
      rsp_stall <= (stall_left > 0);
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      logic [DW-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_deviates.size() == 0) begin
            report_mismatch("result with nothing pending", '0, rsp_deviate_numerator);
         end else begin
            want = pending_deviates.pop_front();
            if (rsp_deviate_numerator !== want)
               report_mismatch("deviate_numerator", want, rsp_deviate_numerator);
         end
      end
   end

   // stop a hung run
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int         sent;
      int         burst_len;
      bit         paused;
      rng_op_type op;

      gen_a = '0;
      gen_b = '0;
      prev_deviate = '0;
      for (int i = 0; i < SLOTS; i++)
         shuffle_bank[i] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows
      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_request(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].seed);
      wait_drained();

      // random bursts: occasional reseed, then runs of draws with a rare reseed mixed in
      sent = 0;
      paused = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
         recv_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
         if ($urandom_range(0, 4) == 0) begin
            send_request(OP_RESEED, pick_seed());
            sent++;
         end
         burst_len = $urandom_range(4, 40);
         for (int k = 0; k < burst_len; k++) begin
            op = ($urandom_range(0, 19) == 0) ? OP_RESEED : OP_DRAW;
            send_request(op, (op == OP_RESEED) ? pick_seed() : DW'($urandom));
            sent++;
         end
         if (!paused && sent >= RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end
      end

      // drain and settle
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_deviates.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/crng_pkg.sv
hw/rtl/crng_ram.sv
hw/rtl/crng_mod_step.sv
hw/rtl/crng_index.sv
hw/rtl/combined_lcg_shuffle_rng_unit.sv
bench/combined_lcg_shuffle_rng_unit_test.sv
